### hdl/assert_macros.svh
// Assertion macros shared by the filter's RTL.
// AST_IMPLY checks an overlapping implication, AST_NEXT a next-cycle one.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AST_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AST_IMPLY(lbl, clk, rst_n, ante, cons)
`define AST_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### hdl/iir_tdf_pkg.sv
package iir_tdf_pkg;

    localparam int C_SAMPLE_BITS    = 24;
    localparam int C_COEF_BITS      = 32;
    localparam int C_ACC_BITS       = 48;
    localparam int C_ACC_FRAC_BITS  = 12;
    localparam int C_TAPS           = 3;
    localparam int C_COEF_FRAC_BITS = 28;
    localparam int C_NUM_REGS       = 7;
    localparam int C_CFG_IDX_BITS   = 3;

    // register indexes on the configuration port
    localparam logic [C_CFG_IDX_BITS-1:0] REG_B0 = 3'd0;
    localparam logic [C_CFG_IDX_BITS-1:0] REG_B1 = 3'd1;
    localparam logic [C_CFG_IDX_BITS-1:0] REG_B2 = 3'd2;
    localparam logic [C_CFG_IDX_BITS-1:0] REG_A1 = 3'd3;
    localparam logic [C_CFG_IDX_BITS-1:0] REG_A2 = 3'd4;
    localparam logic [C_CFG_IDX_BITS-1:0] REG_Z0 = 3'd5;
    localparam logic [C_CFG_IDX_BITS-1:0] REG_Z1 = 3'd6;

    // one product through the shared multiplier
    typedef enum logic [2:0] {
        OP_NONE,
        OP_Z0,
        OP_Z1,
        OP_B0,
        OP_B1,
        OP_B2,
        OP_A1,
        OP_A2
    } t_op;

    typedef struct packed {
        logic signed [C_SAMPLE_BITS-1:0] sample;
        logic                            block_start;
    } t_in;

    typedef struct packed {
        logic signed [C_SAMPLE_BITS-1:0] filtered;
        logic                            overflow;
    } t_out;

    typedef struct packed {
        logic load;
        t_op  op;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

### hdl/iir_tdf_ctrl.sv
`include "assert_macros.svh"

module iir_tdf_ctrl #(
    parameter int TAPS = iir_tdf_pkg::C_TAPS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_block_start,
    output logic                 o_in_ready,
    input  iir_tdf_pkg::t_dp_sts i_sts,
    output iir_tdf_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_DONE
    } t_state;

    localparam iir_tdf_pkg::t_op LAST_OP =
        (TAPS >= 3) ? iir_tdf_pkg::OP_A2 : iir_tdf_pkg::OP_A1;

    t_state           r_state;
    iir_tdf_pkg::t_op r_op;

    function automatic iir_tdf_pkg::t_op f_next(input iir_tdf_pkg::t_op op);
        case (op)
            iir_tdf_pkg::OP_Z0: return (TAPS >= 3) ? iir_tdf_pkg::OP_Z1 : iir_tdf_pkg::OP_B0;
            iir_tdf_pkg::OP_Z1: return iir_tdf_pkg::OP_B0;
            iir_tdf_pkg::OP_B0: return iir_tdf_pkg::OP_B1;
            iir_tdf_pkg::OP_B1: return (TAPS >= 3) ? iir_tdf_pkg::OP_B2 : iir_tdf_pkg::OP_A1;
            iir_tdf_pkg::OP_B2: return iir_tdf_pkg::OP_A1;
            iir_tdf_pkg::OP_A1: return iir_tdf_pkg::OP_A2;
            default:            return iir_tdf_pkg::OP_NONE;
        endcase
    endfunction

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_cmd.load      = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.op        = r_op;
    assign o_cmd.out_load  = (r_state == S_DONE) && i_sts.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= iir_tdf_pkg::OP_NONE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= i_block_start ? iir_tdf_pkg::OP_Z0 : iir_tdf_pkg::OP_B0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (r_op == LAST_OP) begin
                        r_op    <= iir_tdf_pkg::OP_NONE;
                        r_state <= S_DRAIN;
                    end else begin
                        r_op <= f_next(r_op);
                    end
                end
                S_DRAIN: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_op    <= iir_tdf_pkg::OP_NONE;
                end
            endcase
        end
    end

    `AST_IMPLY(a_run_has_op, i_clk, i_rst_n, r_state == S_RUN, r_op != iir_tdf_pkg::OP_NONE)
    `AST_NEXT(a_drain_done, i_clk, i_rst_n, r_state == S_DRAIN, r_state == S_DONE)
    `AST_NEXT(a_load_starts, i_clk, i_rst_n, o_cmd.load, (r_state == S_RUN) && ((r_op == iir_tdf_pkg::OP_Z0) || (r_op == iir_tdf_pkg::OP_B0)))

endmodule

### hdl/iir_tdf_dp.sv
`include "assert_macros.svh"

module iir_tdf_dp #(
    parameter int TAPS           = iir_tdf_pkg::C_TAPS,
    parameter int COEF_FRAC_BITS = iir_tdf_pkg::C_COEF_FRAC_BITS
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  iir_tdf_pkg::t_in                            i_in,
    input  logic                                        i_cfg_we,
    input  logic [iir_tdf_pkg::C_CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic signed [iir_tdf_pkg::C_COEF_BITS-1:0]  i_cfg_data,
    input  iir_tdf_pkg::t_dp_cmd                        i_cmd,
    output iir_tdf_pkg::t_dp_sts                        o_sts,
    output logic                                        o_out_valid,
    input  logic                                        i_out_ready,
    output iir_tdf_pkg::t_out                           o_out
);

    localparam int SB    = iir_tdf_pkg::C_SAMPLE_BITS;
    localparam int CW    = iir_tdf_pkg::C_COEF_BITS;
    localparam int AW    = iir_tdf_pkg::C_ACC_BITS;
    localparam int AFB   = iir_tdf_pkg::C_ACC_FRAC_BITS;
    localparam int SHIFT = COEF_FRAC_BITS - AFB;
    localparam int PW    = SB + CW;
    localparam int SW    = PW - SHIFT;
    localparam int EW    = ((SW > AW) ? SW : AW) + 2;
    localparam int YW    = AW + 1 - AFB;

    localparam logic signed [AW-1:0] ACC_MAX   = {1'b0, {(AW-1){1'b1}}};
    localparam logic signed [AW-1:0] ACC_MIN   = {1'b1, {(AW-1){1'b0}}};
    localparam logic signed [EW-1:0] ACC_MAX_E = EW'(ACC_MAX);
    localparam logic signed [EW-1:0] ACC_MIN_E = EW'(ACC_MIN);
    localparam logic signed [AW:0]   HALF      = (AW+1)'(1) << (AFB - 1);
    localparam logic signed [SB-1:0] Y_MAX     = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] Y_MIN     = {1'b1, {(SB-1){1'b0}}};
    localparam logic signed [YW-1:0] Y_MAX_E   = YW'(Y_MAX);
    localparam logic signed [YW-1:0] Y_MIN_E   = YW'(Y_MIN);
    localparam logic signed [CW-1:0] ONE       = CW'(1) << COEF_FRAC_BITS;

    logic signed [CW-1:0] r_coef [iir_tdf_pkg::C_NUM_REGS];
    logic signed [SB-1:0] r_x;
    logic signed [SB-1:0] r_y;
    logic                 r_ovf;
    logic signed [PW-1:0] r_prod;
    iir_tdf_pkg::t_op     r_op_q;
    logic signed [AW-1:0] r_d1;
    logic signed [AW-1:0] r_d2;
    logic signed [EW-1:0] r_s1;
    logic signed [EW-1:0] r_s2;
    iir_tdf_pkg::t_out    r_out;
    logic                 r_out_valid;

    logic signed [SB-1:0] mul_a;
    logic signed [CW-1:0] mul_c;
    logic signed [SW-1:0] sc;
    logic signed [EW-1:0] sc_e;
    logic signed [AW-1:0] acc;
    logic signed [AW:0]   rnd;
    logic signed [YW-1:0] y_wide;
    logic signed [SB-1:0] y_next;
    logic                 ovf_next;

    function automatic logic signed [AW-1:0] f_sat(input logic signed [EW-1:0] v);
        if (v > ACC_MAX_E) begin
            return ACC_MAX;
        end else if (v < ACC_MIN_E) begin
            return ACC_MIN;
        end
        return v[AW-1:0];
    endfunction

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < iir_tdf_pkg::C_NUM_REGS; i++) begin
                r_coef[i] <= '0;
            end
            r_coef[iir_tdf_pkg::REG_B0] <= ONE;
        end else if (i_cfg_we && (int'(i_cfg_index) < iir_tdf_pkg::C_NUM_REGS)) begin
            r_coef[i_cfg_index] <= i_cfg_data;
        end
    end

    // Operand select for the shared multiplier
    always_comb begin
        mul_a = r_x;
        mul_c = r_coef[iir_tdf_pkg::REG_B0];
        case (i_cmd.op)
            iir_tdf_pkg::OP_Z0: mul_c = r_coef[iir_tdf_pkg::REG_Z0];
            iir_tdf_pkg::OP_Z1: mul_c = r_coef[iir_tdf_pkg::REG_Z1];
            iir_tdf_pkg::OP_B0: mul_c = r_coef[iir_tdf_pkg::REG_B0];
            iir_tdf_pkg::OP_B1: mul_c = r_coef[iir_tdf_pkg::REG_B1];
            iir_tdf_pkg::OP_B2: mul_c = r_coef[iir_tdf_pkg::REG_B2];
            iir_tdf_pkg::OP_A1: begin
                mul_a = r_y;
                mul_c = r_coef[iir_tdf_pkg::REG_A1];
            end
            iir_tdf_pkg::OP_A2: begin
                mul_a = r_y;
                mul_c = r_coef[iir_tdf_pkg::REG_A2];
            end
            default: ;
        endcase
    end

    // Product stage: scale by floor shift, then output rounding and saturation
    assign sc       = r_prod[PW-1:SHIFT];
    assign sc_e     = EW'(sc);
    assign acc      = f_sat(sc_e + EW'(r_d1));
    assign rnd      = (AW+1)'(acc) + HALF;
    assign y_wide   = rnd[AW:AFB];
    assign ovf_next = (y_wide > Y_MAX_E) || (y_wide < Y_MIN_E);
    assign y_next   = (y_wide > Y_MAX_E) ? Y_MAX :
                      (y_wide < Y_MIN_E) ? Y_MIN : y_wide[SB-1:0];

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= i_in.sample;
        end
        r_prod <= mul_a * mul_c;
        case (r_op_q)
            iir_tdf_pkg::OP_B0: begin
                r_y   <= y_next;
                r_ovf <= ovf_next;
            end
            iir_tdf_pkg::OP_B1: r_s1 <= sc_e + EW'(r_d2);
            iir_tdf_pkg::OP_B2: r_s2 <= sc_e;
            default: ;
        endcase
        if (i_cmd.out_load) begin
            r_out.filtered <= r_y;
            r_out.overflow <= r_ovf;
        end
    end

    // Delay state and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_q      <= iir_tdf_pkg::OP_NONE;
            r_d1        <= '0;
            r_d2        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_op_q <= i_cmd.op;
            case (r_op_q)
                iir_tdf_pkg::OP_Z0: r_d1 <= f_sat(sc_e);
                iir_tdf_pkg::OP_Z1: begin
                    if (TAPS >= 3) begin
                        r_d2 <= f_sat(sc_e);
                    end
                end
                iir_tdf_pkg::OP_A1: r_d1 <= f_sat(r_s1 - sc_e);
                iir_tdf_pkg::OP_A2: begin
                    if (TAPS >= 3) begin
                        r_d2 <= f_sat(r_s2 - sc_e);
                    end
                end
                default: ;
            endcase
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out          = r_out;

    `AST_NEXT(a_out_load_valid, i_clk, i_rst_n, i_cmd.out_load, r_out_valid)
    `AST_IMPLY(a_ovf_at_rail, i_clk, i_rst_n, r_out_valid && r_out.overflow, (r_out.filtered == Y_MAX) || (r_out.filtered == Y_MIN))
    `AST_IMPLY(a_two_tap_zero, i_clk, i_rst_n, TAPS < 3, r_d2 == '0)

endmodule

### hdl/iir_transposed_df2_filter.sv
// Second-order IIR section in transposed direct form II (leading denominator
// coefficient one). Each input beat carries a signed 24-bit sample and a block
// start flag; each output beat carries the rounded, saturated 24-bit result and
// an overflow flag. Coefficients b0, b1, b2, a1, a2 and the initial-condition
// factors z0, z1 are signed Q(31-COEF_FRAC_BITS).COEF_FRAC_BITS registers
// written on the config channel (indexes 0..6 in that order; index 7 is
// dropped); write them only while the filter is idle. The two 48-bit delays
// hold 12 fraction bits and saturate on update. One shared 24x32 multiplier
// forms the products one per cycle (b0, b1, b2, a1, a2 with TAPS = 3; b0,
// b1, a1 with TAPS = 2), after z0, z1 on a block start beat (z0 only with
// TAPS = 2, which has no z1 product). A new sample is taken only once the
// last result is loaded into the output register, which waits for ready
// while it holds an unread one. The output register holds one finished
// result while the next sample is accepted and filtered.

`include "assert_macros.svh"

module iir_transposed_df2_filter #(
    parameter int TAPS           = iir_tdf_pkg::C_TAPS,
    parameter int COEF_FRAC_BITS = iir_tdf_pkg::C_COEF_FRAC_BITS
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    // sample channel
    input  logic                                       i_in_valid,
    output logic                                       o_in_ready,
    input  iir_tdf_pkg::t_in                           i_in,
    // result channel
    output logic                                       o_out_valid,
    input  logic                                       i_out_ready,
    output iir_tdf_pkg::t_out                          o_out,
    // configuration write channel
    input  logic                                       i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  logic [iir_tdf_pkg::C_CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic signed [iir_tdf_pkg::C_COEF_BITS-1:0] i_cfg_data
);

    iir_tdf_pkg::t_dp_cmd cmd;
    iir_tdf_pkg::t_dp_sts sts;

    // Config writes go straight into the coefficient registers; always take them.
    assign o_cfg_ready = 1'b1;

    // Sequence the products: optional z0/z1 load, b0, then the b1/b2/a1/a2
    // delay updates, then the output load.
    iir_tdf_ctrl #(
        .TAPS (TAPS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_block_start (i_in.block_start),
        .o_in_ready    (o_in_ready),
        .i_sts         (sts),
        .o_cmd         (cmd)
    );

    // Hold coefficients and delays, run the multiplier and the accumulate.
    iir_tdf_dp #(
        .TAPS           (TAPS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    `AST_IMPLY(a_no_accept_busy, i_clk, i_rst_n, i_in_valid && o_in_ready, cmd.op == iir_tdf_pkg::OP_NONE)
    `AST_NEXT(a_accept_drops_ready, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `AST_IMPLY(a_out_load_free, i_clk, i_rst_n, cmd.out_load, !o_out_valid || i_out_ready)

endmodule
